[hdl/tgarle_pkg.sv]
// ----------------------------------------------------------------------------
// tgarle_pkg
// shared types and constants of the targa pixel stream rle decoder
// ----------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_DEPTH   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RLE_ENABLE    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_TO_BOTTOM = 3'd4;

  localparam logic [15:0] RESET_IMAGE_WIDTH   = 16'd256;
  localparam logic [15:0] RESET_IMAGE_HEIGHT  = 16'd256;
  localparam logic [1:0]  RESET_PIXEL_DEPTH   = 2'd2;
  localparam logic        RESET_RLE_ENABLE    = 1'b1;
  localparam logic        RESET_TOP_TO_BOTTOM = 1'b0;

  localparam logic [1:0] DEPTH_INDEX8  = 2'd0;
  localparam logic [1:0] DEPTH_RGB555  = 2'd1;
  localparam logic [1:0] DEPTH_RGB24   = 2'd2;
  localparam logic [1:0] DEPTH_RGBA32  = 2'd3;

  localparam logic [7:0] RUN_BIAS = 8'd127;
  localparam logic [7:0] CHAN_MASK = 8'hf8;

  localparam int MIN_WIDTH   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  pixel_depth;
    logic        rle_enable;
    logic        top_to_bottom;
  } cfg_t;

  typedef struct packed {
    logic        is_start;
    logic [31:0] pixel;
    logic [7:0]  count;
    logic        more;
  } job_t;

endpackage

`default_nettype wire

[hdl/tgarle_front.sv]
// ----------------------------------------------------------------------------
// tgarle_front
// byte intake: packet headers, pixel assembly and job issue to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              cmd,
  input  wire logic [7:0]        data_byte,
  input  wire tgarle_pkg::cfg_t  cfg,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output tgarle_pkg::job_t       push_job
);

  logic [7:0]  packet_left;
  logic        packet_is_run;
  logic        awaiting_header;
  logic [1:0]  byte_index;
  logic [31:0] pixel_gather;

  logic        accept;
  logic        is_header;
  logic        complete;
  logic [1:0]  byte_inc;
  logic [2:0]  need;
  logic [31:0] gather_new;
  logic [31:0] pixel;
  logic        run_eff;
  logic [7:0]  left_dec;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  assign is_header  = cfg.rle_enable && awaiting_header;
  assign gather_new = pixel_gather | ({24'd0, data_byte} << {byte_index, 3'b000});
  assign byte_inc   = byte_index + 2'd1;
  assign need       = {1'b0, cfg.pixel_depth} + 3'd1;
  assign complete   = (byte_inc == 2'd0) || ({1'b0, byte_inc} >= need);
  assign run_eff    = cfg.rle_enable && packet_is_run;
  assign left_dec   = (packet_left != 8'd0) ? packet_left - 8'd1 : 8'd0;

  always_comb begin
    case (cfg.pixel_depth)
      tgarle_pkg::DEPTH_INDEX8: pixel = {24'd0, gather_new[7:0]};
      tgarle_pkg::DEPTH_RGB555: pixel = {8'd0,
                                         {gather_new[14:10], 3'b000} & tgarle_pkg::CHAN_MASK,
                                         {gather_new[9:5], 3'b000} & tgarle_pkg::CHAN_MASK,
                                         {gather_new[4:0], 3'b000} & tgarle_pkg::CHAN_MASK};
      tgarle_pkg::DEPTH_RGB24:  pixel = {8'd0, gather_new[23:0]};
      default:                  pixel = gather_new;
    endcase
  end

  assign push_valid        = accept && (cmd || (!is_header && complete));
  assign push_job.is_start = cmd;
  assign push_job.pixel    = pixel;
  assign push_job.count    = run_eff ? packet_left : 8'd1;
  assign push_job.more     = cfg.rle_enable && !packet_is_run && (packet_left > 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_left     <= 8'd0;
      packet_is_run   <= 1'b0;
      awaiting_header <= 1'b1;
      byte_index      <= 2'd0;
      pixel_gather    <= 32'd0;
    end else if (accept) begin
      if (cmd) begin
        packet_left     <= 8'd0;
        packet_is_run   <= 1'b0;
        awaiting_header <= 1'b1;
        byte_index      <= 2'd0;
        pixel_gather    <= 32'd0;
      end else if (is_header) begin
        packet_is_run   <= data_byte[7];
        packet_left     <= data_byte[7] ? data_byte - tgarle_pkg::RUN_BIAS
                                        : data_byte + 8'd1;
        awaiting_header <= 1'b0;
        byte_index      <= 2'd0;
        pixel_gather    <= 32'd0;
      end else if (!complete) begin
        byte_index   <= byte_inc;
        pixel_gather <= gather_new;
      end else begin
        byte_index   <= 2'd0;
        pixel_gather <= 32'd0;
        if (cfg.rle_enable) begin
          if (packet_is_run) begin
            packet_left     <= 8'd0;
            awaiting_header <= 1'b1;
          end else begin
            packet_left     <= left_dec;
            awaiting_header <= (left_dec == 8'd0);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/tgarle_queue.sv]
// ----------------------------------------------------------------------------
// tgarle_queue
// short job queue between the byte front and the span back
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire tgarle_pkg::job_t  push_job,
  output logic                   head_valid,
  input  wire logic              pop,
  output tgarle_pkg::job_t       head_job
);

  tgarle_pkg::job_t                 slots [tgarle_pkg::QUEUE_DEPTH];
  logic [tgarle_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [tgarle_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [tgarle_pkg::QUEUE_AW:0]    fill;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (fill != (tgarle_pkg::QUEUE_AW+1)'(tgarle_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + (tgarle_pkg::QUEUE_AW)'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + (tgarle_pkg::QUEUE_AW)'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + (tgarle_pkg::QUEUE_AW+1)'(1);
        2'b01:   fill <= fill - (tgarle_pkg::QUEUE_AW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/tgarle_back.sv]
// ----------------------------------------------------------------------------
// tgarle_back
// span engine: splits pixel jobs at row ends, flips rows, flags overrun
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_back #(
  parameter int COORD_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tgarle_pkg::cfg_t  cfg,
  input  wire logic              head_valid,
  input  wire tgarle_pkg::job_t  head_job,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [15:0]            out_row,
  output logic [15:0]            out_column,
  output logic [7:0]             span_length,
  output logic [31:0]            pixel_value,
  output logic                   last_span,
  output logic                   corrupt
);

  typedef enum logic [1:0] {
    ST_RUNNING,
    ST_DONE,
    ST_ERROR
  } status_t;

  status_t               status;
  logic [COORD_BITS-1:0] col_pos;
  logic [COORD_BITS-1:0] row_pos;
  logic                  busy;
  logic                  err_pending;
  logic [31:0]           cur_pix;
  logic [7:0]            cur_n;
  logic                  cur_more;

  logic [COORD_BITS-1:0] w_raw;
  logic [COORD_BITS-1:0] h_raw;
  logic [COORD_BITS-1:0] w_eff;
  logic [COORD_BITS-1:0] h_eff;
  logic                  advance;
  logic [31:0]           src_pix;
  logic [7:0]            src_n;
  logic                  src_more;
  logic [COORD_BITS-1:0] avail;
  logic [7:0]            len;
  logic [COORD_BITS-1:0] col_sum;
  logic                  wrap;
  logic [COORD_BITS-1:0] col_next;
  logic [COORD_BITS-1:0] row_next;
  logic [7:0]            n_rem;
  logic                  img_end;
  logic                  overrun;
  logic [COORD_BITS-1:0] dest_row;
  logic                  start_span;

  assign w_raw = cfg.image_width[COORD_BITS-1:0];
  assign h_raw = cfg.image_height[COORD_BITS-1:0];
  assign w_eff = (w_raw < COORD_BITS'(tgarle_pkg::MIN_WIDTH))
               ? COORD_BITS'(tgarle_pkg::MIN_WIDTH) : w_raw;
  assign h_eff = (h_raw == '0) ? COORD_BITS'(1) : h_raw;

  assign advance  = !out_valid || out_ready;
  assign src_pix  = busy ? cur_pix  : head_job.pixel;
  assign src_n    = busy ? cur_n    : head_job.count;
  assign src_more = busy ? cur_more : head_job.more;

  assign avail    = (col_pos < w_eff) ? w_eff - col_pos : COORD_BITS'(1);
  assign len      = (avail < COORD_BITS'(src_n)) ? avail[7:0] : src_n;
  assign col_sum  = col_pos + COORD_BITS'(len);
  assign wrap     = (col_sum >= w_eff);
  assign col_next = wrap ? '0 : col_sum;
  assign row_next = wrap ? row_pos + COORD_BITS'(1) : row_pos;
  assign n_rem    = src_n - len;
  assign img_end  = (row_next >= h_eff);
  assign overrun  = (n_rem != 8'd0) || src_more;
  assign dest_row = cfg.top_to_bottom ? row_pos : h_eff - COORD_BITS'(1) - row_pos;

  assign start_span = !busy && !err_pending && head_valid && !head_job.is_start &&
                      (status == ST_RUNNING) && (row_pos < h_eff) &&
                      (head_job.count != 8'd0);
  assign pop        = advance && !busy && !err_pending && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      status      <= ST_RUNNING;
      col_pos     <= '0;
      row_pos     <= '0;
      busy        <= 1'b0;
      err_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b0;
      if (err_pending) begin
        err_pending <= 1'b0;
        out_valid   <= 1'b1;
        out_row     <= 16'd0;
        out_column  <= 16'd0;
        span_length <= 8'd0;
        pixel_value <= 32'd0;
        last_span   <= 1'b1;
        corrupt     <= 1'b1;
      end else if (busy || start_span) begin
        out_valid   <= 1'b1;
        out_row     <= 16'(dest_row);
        out_column  <= 16'(col_pos);
        span_length <= len;
        pixel_value <= src_pix;
        corrupt     <= 1'b0;
        last_span   <= 1'b0;
        col_pos     <= col_next;
        row_pos     <= row_next;
        cur_pix     <= src_pix;
        cur_n       <= n_rem;
        cur_more    <= src_more;
        if (img_end) begin
          busy <= 1'b0;
          if (overrun) begin
            err_pending <= 1'b1;
            status      <= ST_ERROR;
          end else begin
            last_span <= 1'b1;
            status    <= ST_DONE;
          end
        end else begin
          busy <= (n_rem != 8'd0);
        end
      end else if (head_valid) begin
        if (head_job.is_start) begin
          status  <= ST_RUNNING;
          col_pos <= '0;
          row_pos <= '0;
        end else if ((status == ST_RUNNING) && (row_pos >= h_eff)) begin
          status      <= ST_ERROR;
          out_valid   <= 1'b1;
          out_row     <= 16'd0;
          out_column  <= 16'd0;
          span_length <= 8'd0;
          pixel_value <= 32'd0;
          last_span   <= 1'b1;
          corrupt     <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/tga_pixel_stream_rle_decoder.sv]
// ----------------------------------------------------------------------------
// tga_pixel_stream_rle_decoder
// targa pixel data decoder: bytes in, row spans for a frame store out
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready with cmd and data_byte; cmd high starts a
// new image, otherwise data_byte is the next byte of the pixel data.
// output channel: out_valid/out_ready carrying one span per transaction
// (out_row, out_column, span_length, pixel_value, last_span, corrupt).
// configuration: cfg_write_enable/cfg_index/cfg_data, written between images.
// the front takes one byte per cycle while the four-entry job queue has room;
// header and partial-pixel bytes produce no job.
// the back turns one queued job into spans at one span per cycle while the
// receiver takes them; a pixel whose run crosses k row ends gives k+1 spans,
// and an overrun adds one error transaction. a completed pixel's job is
// registered in the queue before the back registers its first span.
// a stalled receiver holds the output register; the back then stops, the
// queue fills and in_ready falls after four further jobs.
// reset (rst, synchronous) clears the decoder and loads the register
// defaults: width 256, height 256, 24 bit pixels, rle on, bottom-up rows.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_pixel_stream_rle_decoder #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  cmd,
  input  wire logic [7:0]                            data_byte,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [15:0]                                out_row,
  output logic [15:0]                                out_column,
  output logic [7:0]                                 span_length,
  output logic [31:0]                                pixel_value,
  output logic                                       last_span,
  output logic                                       corrupt,
  input  wire logic                                  cfg_write_enable,
  input  wire logic [tgarle_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tgarle_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  tgarle_pkg::cfg_t cfg;
  logic             push_valid;
  logic             push_ready;
  tgarle_pkg::job_t push_job;
  logic             head_valid;
  tgarle_pkg::job_t head_job;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= tgarle_pkg::RESET_IMAGE_WIDTH;
      cfg.image_height  <= tgarle_pkg::RESET_IMAGE_HEIGHT;
      cfg.pixel_depth   <= tgarle_pkg::RESET_PIXEL_DEPTH;
      cfg.rle_enable    <= tgarle_pkg::RESET_RLE_ENABLE;
      cfg.top_to_bottom <= tgarle_pkg::RESET_TOP_TO_BOTTOM;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        tgarle_pkg::REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data;
        tgarle_pkg::REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data;
        tgarle_pkg::REG_PIXEL_DEPTH:   cfg.pixel_depth   <= cfg_data[1:0];
        tgarle_pkg::REG_RLE_ENABLE:    cfg.rle_enable    <= cfg_data[0];
        tgarle_pkg::REG_TOP_TO_BOTTOM: cfg.top_to_bottom <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tgarle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  tgarle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .head_valid (head_valid),
    .pop        (pop),
    .head_job   (head_job)
  );

  tgarle_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_column  (out_column),
    .span_length (span_length),
    .pixel_value (pixel_value),
    .last_span   (last_span),
    .corrupt     (corrupt)
  );

endmodule

`default_nettype wire

[hdl/tgarle_checker.sv]
// ----------------------------------------------------------------------------
// tgarle_checker
// port-level checks of the decoder output channel
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_row,
  input wire logic [15:0] out_column,
  input wire logic [7:0]  span_length,
  input wire logic [31:0] pixel_value,
  input wire logic        last_span,
  input wire logic        corrupt
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_column) &&
      $stable(span_length) && $stable(pixel_value) && $stable(last_span) &&
      $stable(corrupt))
    else $error("output transaction changed while stalled");

  // error transaction is all zero and closes the image
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && corrupt |-> last_span && span_length == 8'd0 && out_row == 16'd0 &&
      out_column == 16'd0 && pixel_value == 32'd0)
    else $error("malformed error transaction");

  // regular spans carry one to 128 pixels
  a_span_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !corrupt |-> span_length != 8'd0 && span_length <= 8'd128)
    else $error("span length out of range");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind tga_pixel_stream_rle_decoder tgarle_checker u_tgarle_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_row     (out_row),
  .out_column  (out_column),
  .span_length (span_length),
  .pixel_value (pixel_value),
  .last_span   (last_span),
  .corrupt     (corrupt)
);

`default_nettype wire
